// ----- hdl/wrsa_pkg.sv -----
// ----------------------------------------------------------------------------
// wrsa_pkg
// Shared types and constants of the windowed range stability averager.
// ----------------------------------------------------------------------------
package wrsa_pkg;

  // Window saturation limit for sum and count; the count is 8 bits wide.
  localparam int MAX_SAMPLES = 255;
  localparam logic [7:0] CNT_LIMIT = (MAX_SAMPLES < 255) ? 8'(MAX_SAMPLES) : 8'd255;

  localparam logic [7:0] RANGE_NO_TARGET = 8'd255;
  localparam logic [3:0] STATUS_OK       = 4'd0;
  localparam logic       FUNC_SAMPLE     = 1'b0;
  localparam logic       FUNC_CLOSE      = 1'b1;

  // -1.0 in Q.8
  localparam logic signed [31:0] CAL_NO_DATA = -32'sd256;

  // Configuration register indexes
  localparam logic [1:0] CFG_SPREAD_LIMIT = 2'd0;
  localparam logic [1:0] CFG_CAL_OFFSET   = 2'd1;
  localparam logic [1:0] CFG_CAL_GAIN     = 2'd2;

  // Reset values of the configuration registers
  localparam logic [7:0]         SPREAD_LIMIT_RST = 8'd5;
  localparam logic signed [23:0] CAL_OFFSET_RST   = 24'sd0;
  localparam logic signed [15:0] CAL_GAIN_RST     = 16'sd256;

  // Event queue
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;

  // Divider: (sum << 8) / count, one quotient bit per cycle
  localparam int DIV_STEPS = 24;
  localparam int DIV_CW    = 5;

  typedef enum logic [1:0] {
    EV_GOOD,
    EV_BAD,
    EV_CLOSE
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t   kind;
    logic [7:0] range_mm;
  } ev_t;

  typedef struct packed {
    logic valid;
    ev_t  ev;
  } q_head_t;

  typedef struct packed {
    logic [7:0]         spread_limit;
    logic signed [23:0] cal_offset;
    logic signed [15:0] cal_gain;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- hdl/windowed_range_stability_averager_top.sv -----
// ----------------------------------------------------------------------------
// windowed_range_stability_averager_top
// Collects range samples into a window; a close request reports the mean
// (Q8.8), a calibrated value mean*gain+offset (Q.8) and a stability flag.
// ----------------------------------------------------------------------------
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------
//  in      | in_valid/in_ready   | func, range_mm, range_status
//  out     | out_valid/out_ready | has_data, stable, mean_range,
//          |                     | calibrated_value
//  cfg     | cfg_valid/cfg_ready | cfg_index (0 limit, 1 offset, 2 gain),
//          |                     | cfg_data
//
//  A sample request is handled in the back end's idle state. A close request
//  with data passes divider load, 24 divider steps (one quotient bit per
//  cycle), the divider done step, then multiply and offset add; an empty
//  window skips the divider.
//  Reset is synchronous, active low; no clearing pass is needed.
//  A two-entry queue between front and back keeps input accepted while the
//  back end divides; a full queue drops in_ready. A waiting result holds the
//  back end in its final step until out_ready takes it.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module windowed_range_stability_averager_top (
  input  logic               clk,
  input  logic               rst_n,
  // input requests
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_func,
  input  logic [7:0]         in_range_mm,
  input  logic [3:0]         in_range_status,
  // results
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_has_data,
  output logic               out_stable,
  output logic [15:0]        out_mean_range,
  output logic signed [31:0] out_calibrated_value,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  wrsa_pkg::cfg_t    cfg_r;
  wrsa_pkg::q_head_t q_head;
  logic              q_pop;

  assign cfg_ready = 1'b1;

  // Register file; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.spread_limit <= wrsa_pkg::SPREAD_LIMIT_RST;
      cfg_r.cal_offset   <= wrsa_pkg::CAL_OFFSET_RST;
      cfg_r.cal_gain     <= wrsa_pkg::CAL_GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wrsa_pkg::CFG_SPREAD_LIMIT: cfg_r.spread_limit <= cfg_data[7:0];
        wrsa_pkg::CFG_CAL_OFFSET:   cfg_r.cal_offset   <= $signed(cfg_data);
        wrsa_pkg::CFG_CAL_GAIN:     cfg_r.cal_gain     <= $signed(cfg_data[15:0]);
        default: ;
      endcase
    end
  end

  // Front: classify good, bad and close requests into the queue.
  wrsa_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_range_mm     (in_range_mm),
    .in_range_status (in_range_status),
    .q_head          (q_head),
    .q_pop           (q_pop)
  );

  // Back: window state, divider, calibration and the output register.
  wrsa_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg_r),
    .q_head               (q_head),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_has_data         (out_has_data),
    .out_stable           (out_stable),
    .out_mean_range       (out_mean_range),
    .out_calibrated_value (out_calibrated_value)
  );

endmodule

// ----- hdl/wrsa_front.sv -----
// ----------------------------------------------------------------------------
// wrsa_front
// Accepts requests, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module wrsa_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_func,
  input  logic [7:0]        in_range_mm,
  input  logic [3:0]        in_range_status,
  output wrsa_pkg::q_head_t q_head,
  input  logic              q_pop
);

  wrsa_pkg::ev_t         q_mem [wrsa_pkg::Q_DEPTH];
  logic [wrsa_pkg::Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [wrsa_pkg::Q_AW:0]   count_r;
  wrsa_pkg::ev_t         ev_in;
  logic                  push, pop;

  always_comb begin
    ev_in.range_mm = in_range_mm;
    if (in_func == wrsa_pkg::FUNC_CLOSE) begin
      ev_in.kind = wrsa_pkg::EV_CLOSE;
    end else if (in_range_status != wrsa_pkg::STATUS_OK ||
                 in_range_mm == wrsa_pkg::RANGE_NO_TARGET) begin
      ev_in.kind = wrsa_pkg::EV_BAD;
    end else begin
      ev_in.kind = wrsa_pkg::EV_GOOD;
    end
  end

  assign in_ready     = (count_r != (wrsa_pkg::Q_AW+1)'(wrsa_pkg::Q_DEPTH));
  assign push         = in_valid && in_ready;
  assign pop          = q_pop && (count_r != '0);
  assign q_head.valid = (count_r != '0);
  assign q_head.ev    = q_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= ev_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ----- hdl/wrsa_divider.sv -----
// ----------------------------------------------------------------------------
// wrsa_divider
// Restoring divider, (sum << 8) / count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wrsa_divider (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [15:0]         sum,
  input  logic [7:0]          count,
  output wrsa_pkg::div_stat_t stat,
  output logic [15:0]         quotient
);

  logic [23:0]                 dvd_r;
  logic [7:0]                  dsr_r;
  logic [7:0]                  rem_r, rem_nxt;
  logic [15:0]                 quo_r;
  logic [wrsa_pkg::DIV_CW-1:0] cnt_r;
  logic                        busy_r, done_r;
  logic [8:0]                  trial;
  logic                        ge;

  always_comb begin
    trial   = {rem_r, dvd_r[23]};
    ge      = (trial >= {1'b0, dsr_r});
    rem_nxt = ge ? 8'(trial - {1'b0, dsr_r}) : trial[7:0];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= {sum, 8'd0};
      dsr_r <= count;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[22:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[14:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == wrsa_pkg::DIV_CW'(wrsa_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

// ----- hdl/wrsa_back.sv -----
// ----------------------------------------------------------------------------
// wrsa_back
// Window accumulator and report sequencer: divide, scale, offset, output.
// ----------------------------------------------------------------------------
module wrsa_back (
  input  logic                clk,
  input  logic                rst_n,
  input  wrsa_pkg::cfg_t      cfg,
  input  wrsa_pkg::q_head_t   q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_has_data,
  output logic                out_stable,
  output logic [15:0]         out_mean_range,
  output logic signed [31:0]  out_calibrated_value
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_FIN
  } state_t;

  state_t state_r;

  logic [15:0] sum_r;
  logic [7:0]  cnt_r, min_r, max_r;
  logic        ok_r;

  logic        rep_has_r, rep_ok_r;
  logic [15:0] mean_r;
  logic signed [32:0] prod_r;

  logic               out_valid_r, out_has_r, out_stable_r;
  logic [15:0]        out_mean_r;
  logic signed [31:0] out_cal_r;

  logic [7:0]  rng, min_nxt, max_nxt;
  logic        ok_nxt;
  logic        div_start, out_free;
  logic signed [32:0] prod_nxt;
  logic signed [31:0] cal_nxt;

  wrsa_pkg::div_stat_t div_stat;
  logic [15:0]         div_quo;

  wrsa_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .sum      (sum_r),
    .count    (cnt_r),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  assign rng       = q_head.ev.range_mm;
  assign q_pop     = (state_r == ST_IDLE) && q_head.valid;
  assign div_start = q_pop && (q_head.ev.kind == wrsa_pkg::EV_CLOSE) && (cnt_r != '0);
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    min_nxt  = (rng < min_r) ? rng : min_r;
    max_nxt  = (rng > max_r) ? rng : max_r;
    ok_nxt   = ok_r && ((max_nxt - min_nxt) <= cfg.spread_limit);
    prod_nxt = $signed({1'b0, mean_r}) * cfg.cal_gain;
    // floor(prod / 256) is an arithmetic shift
    cal_nxt  = {{7{prod_r[32]}}, prod_r[32:8]} + {{8{cfg.cal_offset[23]}}, cfg.cal_offset};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      cnt_r       <= '0;
      min_r       <= wrsa_pkg::RANGE_NO_TARGET;
      max_r       <= '0;
      ok_r        <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      // In the final step a free output register is reloaded below.
      if (out_valid_r && out_ready && state_r != ST_FIN) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (q_head.valid) begin
            case (q_head.ev.kind)
              wrsa_pkg::EV_GOOD: begin
                if (cnt_r < wrsa_pkg::CNT_LIMIT) begin
                  sum_r <= sum_r + {8'd0, rng};
                  cnt_r <= cnt_r + 1'b1;
                end
                min_r <= min_nxt;
                max_r <= max_nxt;
                ok_r  <= ok_nxt;
              end
              wrsa_pkg::EV_CLOSE: begin
                rep_has_r <= (cnt_r != '0);
                rep_ok_r  <= ok_r;
                mean_r    <= '0;
                sum_r     <= '0;
                cnt_r     <= '0;
                min_r     <= wrsa_pkg::RANGE_NO_TARGET;
                max_r     <= '0;
                ok_r      <= 1'b1;
                state_r   <= (cnt_r != '0) ? ST_DIV : ST_MUL;
              end
              default: ok_r <= 1'b0;
            endcase
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            mean_r  <= div_quo;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_r  <= prod_nxt;
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_has_r    <= rep_has_r;
            out_stable_r <= rep_ok_r;
            out_mean_r   <= mean_r;
            out_cal_r    <= rep_has_r ? cal_nxt : wrsa_pkg::CAL_NO_DATA;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_has_data         = out_has_r;
  assign out_stable           = out_stable_r;
  assign out_mean_range       = out_mean_r;
  assign out_calibrated_value = out_cal_r;

`ifndef ASSERT_OFF
  a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide state");

  a_div_running: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> div_stat.busy || div_stat.done)
    else $error("divide state without a running divider");

  a_no_data_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_has_r |-> out_mean_r == '0 && out_cal_r == wrsa_pkg::CAL_NO_DATA)
    else $error("empty window result carries data");

  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= wrsa_pkg::CNT_LIMIT)
    else $error("window count beyond its limit");

  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_head.ev.kind == wrsa_pkg::EV_CLOSE |=> cnt_r == '0 && ok_r)
    else $error("window not cleared after close");
`endif

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the windowed range stability averager. Range
// requests are pushed through the valid/ready input with random gaps, every
// window close is predicted from a local model of the window and of the
// configuration, and each report is compared field by field on the output
// side while the receiver stalls at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Index past the last register: the write must leave everything alone.
  localparam logic [1:0] CFG_UNUSED   = 2'd3;
  // Longest close (24 divider steps plus multiply/add), with some slack.
  localparam int         DRAIN_CYCLES = 32;
  localparam int         DRAIN_GUARD  = 20000;
  localparam int         MAX_REPORTS  = 10;

  typedef struct {
    logic               has_data;
    logic               stable;
    logic [15:0]        mean_range;
    logic signed [31:0] calibrated_value;
  } window_report_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_func = wrsa_pkg::FUNC_SAMPLE;
  logic [7:0]         in_range_mm = '0;
  logic [3:0]         in_range_status = wrsa_pkg::STATUS_OK;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_has_data;
  logic               out_stable;
  logic [15:0]        out_mean_range;
  logic signed [31:0] out_calibrated_value;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = wrsa_pkg::CFG_SPREAD_LIMIT;
  logic [23:0]        cfg_data = '0;

  // Local copy of the window, updated on each accepted request, and of the registers.
  logic [15:0]        win_sum;
  logic [7:0]         win_count;
  logic [7:0]         win_min;
  logic [7:0]         win_max;
  logic               win_stable;
  logic [7:0]         spread_limit_q;
  logic signed [23:0] cal_offset_q;
  logic signed [15:0] cal_gain_q;

  window_report_t expected_reports[$];
  int             error_count = 0;

  // Idle bounds, varied by the tests; 0 gives stretches with no idling.
  int unsigned    send_gap_max = 15;
  int unsigned    recv_stall_max = 15;
  // Set by a test to make the receiver hold off once for that many cycles.
  int unsigned    rx_hold_cycles = 0;

  windowed_range_stability_averager_top DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_func              (in_func),
    .in_range_mm          (in_range_mm),
    .in_range_status      (in_range_status),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_has_data         (out_has_data),
    .out_stable           (out_stable),
    .out_mean_range       (out_mean_range),
    .out_calibrated_value (out_calibrated_value),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Window model
  // --------------------------------------------------------------------------
  function automatic void clear_window();
    win_sum    = '0;
    win_count  = '0;
    win_min    = wrsa_pkg::RANGE_NO_TARGET;
    win_max    = '0;
    win_stable = 1'b1;
  endfunction

  // Applies one accepted request; a close leaves its report in the queue.
  function automatic void predict_window_event(input logic f, input logic [7:0] r,
                                               input logic [3:0] s);
    window_report_t rep;
    longint         prod;
    if (f == wrsa_pkg::FUNC_SAMPLE) begin
      if (s != wrsa_pkg::STATUS_OK || r == wrsa_pkg::RANGE_NO_TARGET) begin
        win_stable = 1'b0;
      end else begin
        // Saturated window: sum and count freeze, min/max keep tracking.
        if (win_count < wrsa_pkg::CNT_LIMIT) begin
          win_sum   = win_sum + 16'(r);
          win_count = win_count + 8'd1;
        end
        if (r < win_min) win_min = r;
        if (r > win_max) win_max = r;
        if (win_max - win_min > spread_limit_q) win_stable = 1'b0;
      end
    end else begin
      rep.has_data = (win_count != 0);
      rep.stable   = win_stable;
      if (rep.has_data) begin
        rep.mean_range       = 16'({win_sum, 8'd0} / win_count);
        prod                 = longint'(rep.mean_range) * longint'(cal_gain_q);
        // Arithmetic shift floors toward minus infinity.
        rep.calibrated_value = 32'((prod >>> 8) + longint'(cal_offset_q));
      end else begin
        rep.mean_range       = '0;
        rep.calibrated_value = wrsa_pkg::CAL_NO_DATA;
      end
      expected_reports.push_back(rep);
      clear_window();
    end
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // Valid is left high after acceptance; the next call either reuses it
  // back to back or drops it for its gap.
  task automatic send_range_request(input logic f, input logic [7:0] r,
                                    input logic [3:0] s);
    int unsigned gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_func         <= f;
    in_range_mm     <= r;
    in_range_status <= s;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    predict_window_event(f, r, s);
  endtask

  // Sender pause: nothing offered until every pending report has come back,
  // then long enough for trailing samples to leave the queue.
  task automatic wait_for_reports();
    int guard;
    in_valid <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (expected_reports.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    if (expected_reports.size() != 0) begin
      error_count += expected_reports.size();
      if (error_count <= MAX_REPORTS)
        $display("%0d window reports never arrived", expected_reports.size());
      expected_reports.delete();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [1:0] idx, input logic [23:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    case (idx)
      wrsa_pkg::CFG_SPREAD_LIMIT: spread_limit_q = data[7:0];
      wrsa_pkg::CFG_CAL_OFFSET:   cal_offset_q   = data;
      wrsa_pkg::CFG_CAL_GAIN:     cal_gain_q     = data[15:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all_config(input logic [7:0] lim, input logic [23:0] offs,
                                  input logic [15:0] gain);
    // Upper data bits past the limit and gain register widths are noise.
    write_config(wrsa_pkg::CFG_SPREAD_LIMIT, {16'($urandom), lim});
    write_config(wrsa_pkg::CFG_CAL_OFFSET, offs);
    write_config(wrsa_pkg::CFG_CAL_GAIN, {8'($urandom), gain});
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (want !== got) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("%s mismatch: expected %0d, got %0d", name, want, got);
    end
  endtask

  initial begin : result_checker
    window_report_t want;
    int unsigned    stall;
    wait (rst_n === 1'b1);
    forever begin
      if (rx_hold_cycles != 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end
      stall = $urandom_range(0, recv_stall_max);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      if (expected_reports.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("report with no window close pending: mean %0d cal %0d",
                   out_mean_range, out_calibrated_value);
      end else begin
        want = expected_reports.pop_front();
        check_field("has_data", want.has_data, out_has_data);
        check_field("stable", want.stable, out_stable);
        check_field("mean_range", want.mean_range, out_mean_range);
        check_field("calibrated_value", want.calibrated_value, out_calibrated_value);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // One window: a run of samples clustered around a base, mostly clean, with
  // some bad status, no-target and wild readings mixed in, then a close.
  task automatic send_random_window(input int len);
    int unsigned base;
    int unsigned width;
    int unsigned noise;
    int unsigned r;
    logic [3:0]  s;
    base  = $urandom_range(0, 254);
    width = $urandom_range(0, 12);
    for (int i = 0; i < len; i++) begin
      noise = $urandom_range(0, 19);
      r     = base + $urandom_range(0, width);
      if (r > 254) r = 254;
      s     = wrsa_pkg::STATUS_OK;
      case (noise)
        0: s = 4'($urandom_range(1, 15));
        1: r = wrsa_pkg::RANGE_NO_TARGET;
        2: r = $urandom_range(0, 255);
        3: s = 4'($urandom);
        default: ;
      endcase
      send_range_request(wrsa_pkg::FUNC_SAMPLE, 8'(r), s);
    end
    // Payload of a close is don't-care; drive it random.
    send_range_request(wrsa_pkg::FUNC_CLOSE, 8'($urandom), 4'($urandom));
  endtask

  task automatic run_random_windows(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      // Pick an idling mode per window, including runs with none at all.
      case ($urandom_range(0, 5))
        0: begin send_gap_max = 0;  recv_stall_max = 0;  end
        1: begin send_gap_max = 0;  recv_stall_max = 15; end
        2: begin send_gap_max = 15; recv_stall_max = 0;  end
        default: begin send_gap_max = 15; recv_stall_max = 15; end
      endcase
      // Mostly short windows, an empty one now and then.
      len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
      send_random_window(len);
      sent += len + 1;
    end
    send_gap_max   = 15;
    recv_stall_max = 15;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Runs on the reset register values: limit 5, gain 1.0, offset 0.
  task automatic test_directed_windows();
    // Empty window: no data, stable, -1.0 calibrated.
    send_range_request(wrsa_pkg::FUNC_CLOSE, '0, wrsa_pkg::STATUS_OK);
    // Spread exactly at the limit stays stable.
    send_range_request(wrsa_pkg::FUNC_SAMPLE, 8'd100, wrsa_pkg::STATUS_OK);
    send_range_request(wrsa_pkg::FUNC_SAMPLE, 8'd103, wrsa_pkg::STATUS_OK);
    send_range_request(wrsa_pkg::FUNC_SAMPLE, 8'd105, wrsa_pkg::STATUS_OK);
    send_range_request(wrsa_pkg::FUNC_CLOSE, '0, wrsa_pkg::STATUS_OK);
    // One past the limit clears stable.
    send_range_request(wrsa_pkg::FUNC_SAMPLE, 8'd100, wrsa_pkg::STATUS_OK);
    send_range_request(wrsa_pkg::FUNC_SAMPLE, 8'd106, wrsa_pkg::STATUS_OK);
    send_range_request(wrsa_pkg::FUNC_CLOSE, '0, wrsa_pkg::STATUS_OK);
    // No-target reading only: no data and unstable.
    send_range_request(wrsa_pkg::FUNC_SAMPLE, wrsa_pkg::RANGE_NO_TARGET,
                       wrsa_pkg::STATUS_OK);
    send_range_request(wrsa_pkg::FUNC_CLOSE, '0, wrsa_pkg::STATUS_OK);
    // Bad status, then the range extremes.
    send_range_request(wrsa_pkg::FUNC_SAMPLE, 8'd50, 4'hF);
    send_range_request(wrsa_pkg::FUNC_SAMPLE, 8'd0, wrsa_pkg::STATUS_OK);
    send_range_request(wrsa_pkg::FUNC_SAMPLE, 8'd254, wrsa_pkg::STATUS_OK);
    send_range_request(wrsa_pkg::FUNC_CLOSE, '0, wrsa_pkg::STATUS_OK);
    // Close with a no-target range and all status bits set: fields ignored.
    send_range_request(wrsa_pkg::FUNC_SAMPLE, 8'd7, 4'h8);
    send_range_request(wrsa_pkg::FUNC_CLOSE, wrsa_pkg::RANGE_NO_TARGET, 4'hF);
    // Single sample with the other status bits.
    send_range_request(wrsa_pkg::FUNC_SAMPLE, 8'd1, 4'h7);
    send_range_request(wrsa_pkg::FUNC_SAMPLE, 8'd1, wrsa_pkg::STATUS_OK);
    send_range_request(wrsa_pkg::FUNC_CLOSE, '0, wrsa_pkg::STATUS_OK);
    wait_for_reports();
  endtask

  // Count hits its ceiling; later samples still move min/max.
  task automatic test_count_saturation();
    send_gap_max   = 0;
    recv_stall_max = 3;
    for (int i = 0; i < 270; i++)
      send_range_request(wrsa_pkg::FUNC_SAMPLE, 8'(200 + $urandom_range(0, 3)),
                         wrsa_pkg::STATUS_OK);
    send_range_request(wrsa_pkg::FUNC_CLOSE, '0, wrsa_pkg::STATUS_OK);
    for (int i = 0; i < 258; i++)
      send_range_request(wrsa_pkg::FUNC_SAMPLE, 8'd254, wrsa_pkg::STATUS_OK);
    // Past saturation: this widens the spread and must clear stable.
    send_range_request(wrsa_pkg::FUNC_SAMPLE, 8'd10, wrsa_pkg::STATUS_OK);
    send_range_request(wrsa_pkg::FUNC_CLOSE, '0, wrsa_pkg::STATUS_OK);
    send_gap_max   = 15;
    recv_stall_max = 15;
    wait_for_reports();
  endtask

  task automatic test_config_sweep();
    // Extremes first, then limit 3 with zero gain and offset, then random settings.
    write_all_config(8'd0, 24'h800000, 16'h8000);
    run_random_windows(60);
    wait_for_reports();
    write_all_config(8'd255, 24'h7FFFFF, 16'h7FFF);
    run_random_windows(60);
    wait_for_reports();
    write_all_config(8'd3, 24'h000000, 16'h0000);
    // Unused index must not disturb the registers just written.
    write_config(CFG_UNUSED, 24'($urandom));
    run_random_windows(60);
    wait_for_reports();
    for (int k = 0; k < 3; k++) begin
      write_all_config(8'($urandom_range(0, 16)), 24'($urandom), 16'($urandom));
      run_random_windows(60);
      wait_for_reports();
    end
  endtask

  // Receiver stops long enough for the event queue to fill and in_ready to drop.
  task automatic test_output_backpressure();
    write_all_config(8'd8, 24'($urandom), 16'($urandom_range(0, 1024)));
    send_gap_max   = 2;
    rx_hold_cycles = 400;
    for (int i = 0; i < 30; i++) begin
      if ($urandom_range(0, 1) == 0)
        send_range_request(wrsa_pkg::FUNC_CLOSE, 8'($urandom), 4'($urandom));
      else
        send_range_request(wrsa_pkg::FUNC_SAMPLE, 8'($urandom_range(0, 254)),
                           wrsa_pkg::STATUS_OK);
    end
    send_gap_max = 15;
    wait_for_reports();
  endtask

  task automatic test_random_traffic();
    write_all_config(8'($urandom_range(0, 10)), 24'($urandom), 16'($urandom));
    run_random_windows(150);
    wait_for_reports();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    spread_limit_q = wrsa_pkg::SPREAD_LIMIT_RST;
    cal_offset_q   = wrsa_pkg::CAL_OFFSET_RST;
    cal_gain_q     = wrsa_pkg::CAL_GAIN_RST;
    clear_window();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_windows();
    test_count_saturation();
    test_config_sweep();
    test_output_backpressure();
    test_random_traffic();

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
